// ----- sv/ctfs_pkg.sv -----
// Shared types and constants of the CAN transport frame segmenter.
`default_nettype none

package ctfs_pkg;

  localparam int CF_PAYLOAD_DEF = 6;
  localparam int QUEUE_DEPTH    = 2;
  localparam int FRAME_BYTES    = 8;

  localparam logic [3:0]  PCI_FF      = 4'h1;
  localparam logic [3:0]  PCI_CF      = 4'h2;
  localparam logic [11:0] SF_MAX_LEN  = 12'd7;
  localparam logic [28:0] EXT_ID_MAX  = 29'h7FF;

  typedef struct packed {
    logic [7:0]  msg_byte;
    logic [11:0] msg_length;
    logic        start;
    logic        last;
  } mid_word_t;

  typedef struct packed {
    logic [3:0]                  len;
    logic [FRAME_BYTES-1:0][7:0] data;
  } frame_t;

endpackage

`default_nettype wire

// ----- sv/ctfs_fifo.sv -----
// Small register queue used between the segmenter stages and at the output.
`default_nettype none

module ctfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ctfs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output      logic             full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output      logic             empty,
  output      logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ctfs_front.sv -----
// Front stage: accepts bytes, drops empty messages, marks message start and end.
`default_nettype none

module ctfs_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire logic [7:0]          in_msg_byte,
  input  wire logic [11:0]         in_msg_length,
  input  wire logic                mid_full,
  output      logic                mid_push,
  output      ctfs_pkg::mid_word_t mid_word
);

  logic [11:0] taken_r, taken_nxt;
  logic [11:0] taken_inc;
  logic        last;

  assign taken_inc = taken_r + 12'd1;
  assign last      = (taken_inc >= in_msg_length);
  assign mid_push  = in_push && !mid_full && (in_msg_length != '0);

  always_comb begin
    mid_word.msg_byte   = in_msg_byte;
    mid_word.msg_length = in_msg_length;
    mid_word.start      = (taken_r == '0);
    mid_word.last       = last;
  end

  always_comb begin
    taken_nxt = taken_r;
    if (mid_push) begin
      taken_nxt = last ? '0 : taken_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
    end else begin
      taken_r <= taken_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ctfs_back.sv -----
// Back: builds single, first and consecutive frames; sends full and final ones.
`default_nettype none

module ctfs_back #(
  parameter int CF_PAYLOAD = ctfs_pkg::CF_PAYLOAD_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                mid_empty,
  input  wire ctfs_pkg::mid_word_t mid_word,
  output      logic                mid_pop,
  input  wire logic                out_full,
  output      logic                frame_push,
  output      ctfs_pkg::frame_t    frame
);

  logic [ctfs_pkg::FRAME_BYTES-1:0][7:0] store_r, store_nxt;
  logic [ctfs_pkg::FRAME_BYTES-1:0][7:0] store_base, store_fill;
  logic [3:0] fill_r, fill_nxt, fill_base, fill_inc;
  logic [3:0] seq_r, seq_nxt, seq_base;
  logic       cf_r, cf_nxt, cf_base;
  logic [3:0] limit;
  logic       is_full;

  assign mid_pop = !mid_empty && !out_full;

  always_comb begin
    store_base = store_r;
    fill_base  = fill_r;
    seq_base   = seq_r;
    cf_base    = cf_r;
    if (mid_word.start) begin
      store_base = '0;
      seq_base   = 4'd1;
      cf_base    = 1'b0;
      if (mid_word.msg_length <= ctfs_pkg::SF_MAX_LEN) begin
        store_base[0] = {4'h0, mid_word.msg_length[3:0]};
        fill_base     = 4'd1;
      end else begin
        store_base[0] = {ctfs_pkg::PCI_FF, mid_word.msg_length[11:8]};
        store_base[1] = mid_word.msg_length[7:0];
        fill_base     = 4'd2;
      end
    end
    store_fill                 = store_base;
    store_fill[fill_base[2:0]] = mid_word.msg_byte;
    fill_inc                   = fill_base + 4'd1;
    limit   = cf_base ? 4'(CF_PAYLOAD + 1) : 4'(ctfs_pkg::FRAME_BYTES);
    is_full = (fill_inc >= limit);
  end

  assign frame_push = mid_pop && (mid_word.last || is_full);

  always_comb begin
    frame.len  = fill_inc;
    frame.data = store_fill;
  end

  always_comb begin
    store_nxt = store_r;
    fill_nxt  = fill_r;
    seq_nxt   = seq_r;
    cf_nxt    = cf_r;
    if (mid_pop) begin
      priority if (mid_word.last) begin
        store_nxt = '0;
        fill_nxt  = '0;
        seq_nxt   = 4'd1;
        cf_nxt    = 1'b0;
      end else if (is_full) begin
        store_nxt    = '0;
        store_nxt[0] = {ctfs_pkg::PCI_CF, seq_base};
        fill_nxt     = 4'd1;
        seq_nxt      = seq_base + 4'd1;
        cf_nxt       = 1'b1;
      end else begin
        store_nxt = store_fill;
        fill_nxt  = fill_inc;
        seq_nxt   = seq_base;
        cf_nxt    = cf_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      fill_r  <= '0;
      seq_r   <= 4'd1;
      cf_r    <= 1'b0;
    end else begin
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
      seq_r   <= seq_nxt;
      cf_r    <= cf_nxt;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_push |-> (frame.len != 4'd0) && (frame.len <= 4'(ctfs_pkg::FRAME_BYTES)))
    else $error("frame length out of range");

  a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop && mid_word.last) |-> frame_push)
    else $error("last byte did not close a frame");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < 4'(ctfs_pkg::FRAME_BYTES))
    else $error("fill index left a full frame pending");

  a_cf_pci: assert property (@(posedge clk) disable iff (!rst_n)
    cf_r |-> (store_r[0][7:4] == ctfs_pkg::PCI_CF))
    else $error("consecutive frame without its PCI");

  a_closed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_pop && mid_word.last) |=> (fill_r == 4'd0) && !cf_r)
    else $error("message state not cleared after last byte");

endmodule

`default_nettype wire

// ----- sv/can_tp_frame_segmenter.sv -----
// Top level of the CAN transport frame segmenter.
// Throughput: one message byte per cycle, sustained while out_pop keeps up.
// A byte that completes a frame is written to the byte queue when accepted; the back stage
// then writes the frame to the frame queue once that queue has room, and the out_ ports show it.
// Reset clears the identifier register, both queues and the open message state.
`default_nettype none

module can_tp_frame_segmenter #(
  parameter int CF_PAYLOAD  = ctfs_pkg::CF_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = ctfs_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [28:0] cfg_tx_ident,
  input  wire logic        in_push,
  output      logic        in_full,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic [11:0] in_msg_length,
  output      logic        out_empty,
  input  wire logic        out_pop,
  output      logic [28:0] out_frame_ident,
  output      logic        out_extended_id,
  output      logic [3:0]  out_frame_len,
  output      logic [7:0]  out_data0,
  output      logic [7:0]  out_data1,
  output      logic [7:0]  out_data2,
  output      logic [7:0]  out_data3,
  output      logic [7:0]  out_data4,
  output      logic [7:0]  out_data5,
  output      logic [7:0]  out_data6,
  output      logic [7:0]  out_data7
);

  logic [28:0]         tx_ident_r;
  logic                mid_push, mid_full, mid_pop, mid_empty;
  ctfs_pkg::mid_word_t mid_wr, mid_rd;
  logic                frame_push, out_q_full;
  ctfs_pkg::frame_t    frame_wr, frame_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_ident_r <= '0;
    end else if (cfg_we) begin
      tx_ident_r <= cfg_tx_ident;
    end
  end

  assign in_full = mid_full;

  ctfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_msg_byte   (in_msg_byte),
    .in_msg_length (in_msg_length),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_word      (mid_wr)
  );

  ctfs_fifo #(
    .WIDTH ($bits(ctfs_pkg::mid_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (mid_wr),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rd)
  );

  ctfs_back #(
    .CF_PAYLOAD (CF_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_word   (mid_rd),
    .mid_pop    (mid_pop),
    .out_full   (out_q_full),
    .frame_push (frame_push),
    .frame      (frame_wr)
  );

  ctfs_fifo #(
    .WIDTH ($bits(ctfs_pkg::frame_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (frame_push),
    .full  (out_q_full),
    .wdata (frame_wr),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (frame_rd)
  );

  assign out_frame_ident = tx_ident_r;
  assign out_extended_id = (tx_ident_r > ctfs_pkg::EXT_ID_MAX);
  assign out_frame_len   = frame_rd.len;
  assign out_data0       = frame_rd.data[0];
  assign out_data1       = frame_rd.data[1];
  assign out_data2       = frame_rd.data[2];
  assign out_data3       = frame_rd.data[3];
  assign out_data4       = frame_rd.data[4];
  assign out_data5       = frame_rd.data[5];
  assign out_data6       = frame_rd.data[6];
  assign out_data7       = frame_rd.data[7];

endmodule

`default_nettype wire

// ----- dv/ctfs_frame_checker.sv -----
// Frame predictor and scoreboard for the CAN transport frame segmenter.
module ctfs_frame_checker
  import ctfs_pkg::*;
#(
  parameter int CF_PAYLOAD = CF_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [28:0] cfg_tx_ident,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_msg_byte,
  input  logic [11:0] in_msg_length,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [28:0] out_frame_ident,
  input  logic        out_extended_id,
  input  logic [3:0]  out_frame_len,
  input  logic [7:0]  out_data0,
  input  logic [7:0]  out_data1,
  input  logic [7:0]  out_data2,
  input  logic [7:0]  out_data3,
  input  logic [7:0]  out_data4,
  input  logic [7:0]  out_data5,
  input  logic [7:0]  out_data6,
  input  logic [7:0]  out_data7,
  output int          fail_count,
  output int          frames_pending,
  output int          frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] PCI_SF = 4'h0;

  typedef struct packed {
    logic [28:0]                 ident;
    logic                        ext;
    logic [3:0]                  len;
    logic [FRAME_BYTES-1:0][7:0] data;
  } can_frame_t;

  can_frame_t                  frames_due[$];
  logic [28:0]                 ident_q;
  logic [11:0]                 taken;
  logic [3:0]                  fill;
  logic [FRAME_BYTES-1:0][7:0] store;
  logic [3:0]                  seq;
  int                          errs;
  int                          seen;

  task automatic report(input string msg);
    $display("%0t ctfs_frame_checker: %s", $realtime, msg);
    errs++;
  endtask

  task automatic segment_byte(input logic [7:0] b, input logic [11:0] mlen);
    can_frame_t  f;
    logic        is_last;
    logic        is_full;
    int unsigned lim;
    if (mlen == '0) return;
    if (taken == '0) begin
      store = '0;
      seq   = 4'd1;
      if (mlen <= SF_MAX_LEN) begin
        store[0] = {PCI_SF, mlen[3:0]};
        fill     = 4'd1;
      end else begin
        store[0] = {PCI_FF, mlen[11:8]};
        store[1] = mlen[7:0];
        fill     = 4'd2;
      end
    end
    store[fill[2:0]] = b;
    fill  = fill + 4'd1;
    taken = taken + 12'd1;
    lim     = (store[0][7:4] == PCI_CF) ? 1 + CF_PAYLOAD : FRAME_BYTES;
    is_last = taken >= mlen;
    is_full = fill >= lim;
    if (is_last || is_full) begin
      f.ident = ident_q;
      f.ext   = ident_q > EXT_ID_MAX;
      f.len   = fill;
      f.data  = store;
      frames_due.insert(frames_due.size(), f);
      if (is_last) begin
        taken = '0;
        fill  = '0;
        store = '0;
        seq   = 4'd1;
      end else begin
        store    = '0;
        store[0] = {PCI_CF, seq};
        fill     = 4'd1;
        seq      = seq + 4'd1;
      end
    end
  endtask

  task automatic check_frame();
    can_frame_t got;
    can_frame_t want;
    got.ident = out_frame_ident;
    got.ext   = out_extended_id;
    got.len   = out_frame_len;
    got.data  = {out_data7, out_data6, out_data5, out_data4,
                 out_data3, out_data2, out_data1, out_data0};
    if (frames_due.size() == 0) begin
      report($sformatf("frame %0d arrived with none expected", seen));
    end else begin
      want = frames_due.pop_front();
      if (got.ident !== want.ident)
        report($sformatf("frame %0d ident expected %h got %h", seen, want.ident, got.ident));
      if (got.ext !== want.ext)
        report($sformatf("frame %0d extended_id expected %b got %b", seen, want.ext, got.ext));
      if (got.len !== want.len)
        report($sformatf("frame %0d len expected %0d got %0d", seen, want.len, got.len));
      for (int k = 0; k < FRAME_BYTES; k++) begin
        if (got.data[k] !== want.data[k])
          report($sformatf("frame %0d data%0d expected %h got %h",
                           seen, k, want.data[k], got.data[k]));
      end
    end
    seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ident_q = '0;
      taken   = '0;
      fill    = '0;
      store   = '0;
      seq     = 4'd1;
      frames_due.delete();
    end else begin
      if (cfg_we) ident_q = cfg_tx_ident;
      if (out_pop && !out_empty) check_frame();
      if (in_push && !in_full) segment_byte(in_msg_byte, in_msg_length);
    end
    frames_pending <= frames_due.size();
    frames_checked <= seen;
    fail_count     <= errs;
  end

endmodule

// ----- dv/tb_can_tp_frame_segmenter.sv -----
// Stimulus, clock, reset and verdict for the CAN transport frame segmenter.
module tb_can_tp_frame_segmenter;
  timeunit 1ns;
  timeprecision 1ps;

  import ctfs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 330;
  localparam int NUM_IDENTS  = 5;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [28:0] cfg_tx_ident  = '0;
  logic        in_push       = 1'b0;
  logic [7:0]  in_msg_byte   = '0;
  logic [11:0] in_msg_length = '0;
  logic        out_pop       = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [28:0] out_frame_ident;
  logic        out_extended_id;
  logic [3:0]  out_frame_len;
  logic [7:0]  out_data0;
  logic [7:0]  out_data1;
  logic [7:0]  out_data2;
  logic [7:0]  out_data3;
  logic [7:0]  out_data4;
  logic [7:0]  out_data5;
  logic [7:0]  out_data6;
  logic [7:0]  out_data7;

  logic        steady = 1'b0;
  int          fail_count;
  int          frames_pending;
  int          frames_checked;
  int          bytes_sent;
  int          messages_sent;
  int          settings_used;
  int          stall_cycles;
  logic [28:0] ident_plan [NUM_IDENTS];

  always #10 clk = ~clk;

  can_tp_frame_segmenter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_tx_ident    (cfg_tx_ident),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_msg_byte     (in_msg_byte),
    .in_msg_length   (in_msg_length),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_frame_ident (out_frame_ident),
    .out_extended_id (out_extended_id),
    .out_frame_len   (out_frame_len),
    .out_data0       (out_data0),
    .out_data1       (out_data1),
    .out_data2       (out_data2),
    .out_data3       (out_data3),
    .out_data4       (out_data4),
    .out_data5       (out_data5),
    .out_data6       (out_data6),
    .out_data7       (out_data7)
  );

  ctfs_frame_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_tx_ident    (cfg_tx_ident),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_msg_byte     (in_msg_byte),
    .in_msg_length   (in_msg_length),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_frame_ident (out_frame_ident),
    .out_extended_id (out_extended_id),
    .out_frame_len   (out_frame_len),
    .out_data0       (out_data0),
    .out_data1       (out_data1),
    .out_data2       (out_data2),
    .out_data3       (out_data3),
    .out_data4       (out_data4),
    .out_data5       (out_data5),
    .out_data6       (out_data6),
    .out_data7       (out_data7),
    .fail_count      (fail_count),
    .frames_pending  (frames_pending),
    .frames_checked  (frames_checked)
  );

  always @(posedge clk) begin
    out_pop <= rst_n && (steady || $urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb_can_tp_frame_segmenter: FAIL");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic [11:0] mlen);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 25);
    end
    in_push       <= 1'b1;
    in_msg_byte   <= b;
    in_msg_length <= mlen;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (mlen != '0) bytes_sent++;
  endtask

  task automatic drain_frames(input int extra);
    in_push <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_ident(input logic [28:0] v);
    cfg_we       <= 1'b1;
    cfg_tx_ident <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_message();
    int          r;
    int          n;
    int          i;
    logic [11:0] mlen;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // length changes mid-message, then close with a length of one
      push_word(8'($urandom), 12'($urandom_range(1, 4095)));
      n = $urandom_range(0, 12);
      repeat (n) push_word(8'($urandom), 12'($urandom_range(0, 4095)));
      push_word(8'($urandom), 12'd1);
    end else begin
      if (r < 35)      mlen = 12'($urandom_range(1, 7));
      else if (r < 80) mlen = 12'($urandom_range(8, 40));
      else             mlen = 12'($urandom_range(41, 200));
      for (i = 0; i < mlen; i++) begin
        if ($urandom_range(0, 99) < 3) push_word(8'($urandom), 12'd0);
        push_word(8'($urandom), mlen);
      end
    end
    messages_sent++;
  endtask

  initial begin
    int target;
    int i;
    ident_plan[0] = 29'h7FF;
    ident_plan[1] = 29'h800;
    ident_plan[2] = 29'h1FFFFFFF;
    ident_plan[3] = 29'($urandom);
    ident_plan[4] = 29'h0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_word(8'hFF, 12'd1);
    push_word(8'h00, 12'd0);
    for (i = 0; i < 7; i++) push_word((i % 2) ? 8'hFF : 8'h00, 12'd7);
    for (i = 0; i < 8; i++) push_word(8'(8'h11 * i), 12'd8);
    push_word(8'hA5, 12'd4095);
    push_word(8'h5A, 12'd0);
    push_word(8'h3C, 12'd1);
    push_word(8'h81, 12'd20);
    push_word(8'h7E, 12'd20);
    push_word(8'hC3, 12'd2);
    messages_sent = 5;

    target = bytes_sent;
    for (int p = 0; p < NUM_IDENTS; p++) begin
      drain_frames(4);
      write_ident(ident_plan[p]);
      steady = (p == 2);
      target += PHASE_BYTES;
      while (bytes_sent < target) random_message();
    end
    steady = 1'b0;
    drain_frames(8);

    $display("covered %0d message bytes in %0d messages under %0d identifier settings",
             bytes_sent, messages_sent, settings_used);
    $display("checked %0d frames, %0d mismatches", frames_checked, fail_count);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("tb_can_tp_frame_segmenter: PASS");
    end else begin
      $display("tb_can_tp_frame_segmenter: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ctfs_pkg.sv
sv/ctfs_fifo.sv
sv/ctfs_front.sv
sv/ctfs_back.sv
sv/can_tp_frame_segmenter.sv
dv/ctfs_frame_checker.sv
dv/tb_can_tp_frame_segmenter.sv
